// ----- sv/c8x_pkg.sv -----
// ----------------------------------------------------------------------------
// c8x_pkg - shared types and constants for the CHIP-8 execute unit
// Result kinds and fixed program-counter and font constants.
// ----------------------------------------------------------------------------
package c8x_pkg;

  typedef enum logic [1:0] {
    RK_DONE  = 2'd0,
    RK_WRITE = 2'd1,
    RK_UNSUP = 2'd2
  } result_kind_t;

  localparam logic [11:0] PC_RESET   = 12'd512;
  localparam logic [15:0] FONT_LIMIT = 16'd80;  // address for values above 15
  localparam logic [11:0] PC_STEP    = 12'd2;

endpackage

// ----- sv/chip8_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_execute - CHIP-8 opcode execute unit
// Executes one opcode or one timer tick per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries either an opcode (kind 0) or a timer tick
// (kind 1). The unit takes one transfer at a time and is not ready while
// it works. A tick has its result valid in the cycle after the transfer. A
// plain opcode goes through the execute state, using the shared 8-bit ALU,
// and then the result register. A return adds a state for the stack
// RAM read. BCD (Fx33) runs a digit sequencer that
// subtracts 100 and then 10 through the same ALU, one step a cycle, and emits
// three memory writes and then returns to idle. Register save (Fx55) emits
// X+1 writes, one per cycle plus output backpressure.
// Writing cfg_program_start also loads the program counter; write it only
// while the unit is idle. Unsupported opcodes (00E0, Dxyn, Fx0A, Fx65 and
// undefined 8xyn, Exkk and Fxkk codes) only advance the program counter.
// The call stack is a STACK_DEPTH-entry RAM; a call on a full stack or a
// return on an empty one is ignored.
// ----------------------------------------------------------------------------
module chip8_instruction_execute #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_program_start,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_key_mask,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_mem_addr,
  output logic [7:0]  out_mem_data,
  output logic [11:0] out_next_pc,
  output logic        out_sound_on,
  output logic        out_last
);
  import c8x_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_RET, ST_BCD_H, ST_BCD_T, ST_SAVE, ST_OUT
  } state_t;

  state_t          state_r;
  logic [7:0]      v_r [16];
  logic [15:0]     i_r;
  logic [11:0]     pc_r;
  logic [SCW-1:0]  sc_r;
  logic [7:0]      dt_r, st_r;
  logic [15:0]     op_r, keys_r;
  logic [7:0]      rnd_r;
  logic [7:0]      acc_r;      // BCD remainder
  logic [3:0]      dig_r;      // BCD digit counter
  logic [1:0]      wcnt_r;     // BCD write index
  logic [3:0]      sidx_r;     // save index
  logic            out_valid_r;
  logic [1:0]      rk_r;
  logic [15:0]     addr_r;
  logic [7:0]      data_r;
  logic            last_r;

  // decode fields
  logic [3:0] x, y, n;
  logic [7:0] kk, vx, vy;
  assign x  = op_r[11:8];
  assign y  = op_r[7:4];
  assign n  = op_r[3:0];
  assign kk = op_r[7:0];
  assign vx = v_r[x];
  assign vy = v_r[y];

  // shared ALU: a + b + cin, with op selecting subtract
  logic [7:0] alu_a, alu_b;
  logic       alu_sub;
  logic [8:0] alu_y;
  always_comb begin
    alu_a = vx;
    alu_b = vy;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_BCD_H: begin alu_a = acc_r; alu_b = 8'd100; alu_sub = 1'b1; end
      ST_BCD_T: begin alu_a = acc_r; alu_b = 8'd10;  alu_sub = 1'b1; end
      default: begin
        if (op_r[15:12] == 4'h7) begin
          alu_b = kk;
        end else if (op_r[15:12] == 4'h8 && n == 4'h7) begin
          alu_a = vy; alu_b = vx; alu_sub = 1'b1;
        end else if (op_r[15:12] == 4'h8 && n == 4'h5) begin
          alu_sub = 1'b1;
        end
      end
    endcase
    // alu_y[8]: carry on add, no-borrow on subtract
    alu_y = alu_sub ? ({1'b0, alu_a} + {1'b0, ~alu_b} + 9'd1)
                    : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  // stack RAM
  logic           stk_we;
  logic [SPW-1:0] stk_waddr, stk_raddr;
  logic [11:0]    stk_rdata;
  assign stk_we    = (state_r == ST_EXEC) && (op_r[15:12] == 4'h2)
                     && (sc_r < SCW'(STACK_DEPTH));
  assign stk_waddr = sc_r[SPW-1:0];
  assign stk_raddr = SPW'(sc_r - SCW'(1));

  c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (pc_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  logic key_hit;
  assign key_hit = (vx[7:4] == 4'h0) && keys_r[vx[3:0]];

  assign in_ready = (state_r == ST_IDLE) && !cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      for (int k = 0; k < 16; k++) v_r[k] <= 8'd0;
      i_r         <= 16'd0;
      pc_r        <= PC_RESET;
      sc_r        <= '0;
      dt_r        <= 8'd0;
      st_r        <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_we) begin
            pc_r <= cfg_program_start;
          end else if (in_valid) begin
            op_r   <= in_opcode;
            keys_r <= in_key_mask;
            rnd_r  <= in_random_byte;
            rk_r   <= RK_DONE;
            addr_r <= 16'd0;
            data_r <= 8'd0;
            last_r <= 1'b1;
            if (in_kind) begin
              if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
              if (st_r != 8'd0) st_r <= st_r - 8'd1;
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end else begin
              pc_r    <= pc_r + PC_STEP;
              state_r <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          state_r     <= ST_OUT;
          out_valid_r <= 1'b1;
          case (op_r[15:12])
            4'h0: begin
              if (op_r == 16'h00E0) rk_r <= RK_UNSUP;
              else if (op_r == 16'h00EE && sc_r != '0) begin
                out_valid_r <= 1'b0;
                state_r     <= ST_RET;
              end
            end
            4'h1: pc_r <= op_r[11:0];
            4'h2: begin
              if (sc_r < SCW'(STACK_DEPTH)) begin
                sc_r <= sc_r + SCW'(1);
                pc_r <= op_r[11:0];
              end
            end
            4'h3: if (vx == kk) pc_r <= pc_r + PC_STEP;
            4'h4: if (vx != kk) pc_r <= pc_r + PC_STEP;
            4'h5: if (vx == vy) pc_r <= pc_r + PC_STEP;
            4'h6: v_r[x] <= kk;
            4'h7: v_r[x] <= alu_y[7:0];
            4'h8: begin
              case (n)
                4'h0: v_r[x] <= vy;
                4'h1: v_r[x] <= vx | vy;
                4'h2: v_r[x] <= vx & vy;
                4'h3: v_r[x] <= vx ^ vy;
                4'h4, 4'h5, 4'h7: begin
                  v_r[x]  <= alu_y[7:0];
                  v_r[15] <= {7'd0, alu_y[8]};
                end
                4'h6: begin
                  v_r[x]  <= {1'b0, vx[7:1]};
                  v_r[15] <= {7'd0, vx[0]};
                end
                4'hE: begin
                  v_r[x]  <= {vx[6:0], 1'b0};
                  v_r[15] <= {7'd0, vx[7]};
                end
                default: rk_r <= RK_UNSUP;
              endcase
            end
            4'h9: if (vx != vy) pc_r <= pc_r + PC_STEP;
            4'hA: i_r <= {4'd0, op_r[11:0]};
            4'hB: pc_r <= op_r[11:0] + {4'd0, v_r[0]};
            4'hC: v_r[x] <= rnd_r & kk;
            4'hD: rk_r <= RK_UNSUP;
            4'hE: begin
              if (kk == 8'h9E) begin
                if (key_hit) pc_r <= pc_r + PC_STEP;
              end else if (kk == 8'hA1) begin
                if (!key_hit) pc_r <= pc_r + PC_STEP;
              end else rk_r <= RK_UNSUP;
            end
            default: begin
              case (kk)
                8'h07: v_r[x] <= dt_r;
                8'h15: dt_r <= vx;
                8'h18: st_r <= vx;
                8'h1E: begin
                  i_r     <= i_r + {8'd0, vx};
                  v_r[15] <= {7'd0, ({1'b0, i_r} + {9'd0, vx}) > 17'h0FFF};
                end
                8'h29: i_r <= (vx[7:4] == 4'h0) ? {8'd0, vx[3:0], 4'd0} / 16'd16 * 16'd5
                                                 : FONT_LIMIT;
                8'h33: begin
                  out_valid_r <= 1'b0;
                  acc_r  <= vx;
                  dig_r  <= 4'd0;
                  wcnt_r <= 2'd0;
                  rk_r   <= RK_WRITE;
                  state_r <= ST_BCD_H;
                end
                8'h55: begin
                  rk_r    <= RK_WRITE;
                  addr_r  <= i_r;
                  data_r  <= v_r[0];
                  last_r  <= (x == 4'd0);
                  sidx_r  <= 4'd0;
                  state_r <= ST_SAVE;
                end
                default: rk_r <= RK_UNSUP;
              endcase
            end
          endcase
        end
        ST_RET: begin
          sc_r        <= sc_r - SCW'(1);
          pc_r        <= stk_rdata;
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end
        ST_BCD_H, ST_BCD_T: begin
          if (!out_valid_r) begin
            if (alu_y[8] && state_r != ST_IDLE && !(wcnt_r == 2'd2)) begin
              acc_r <= alu_y[7:0];
              dig_r <= dig_r + 4'd1;
            end else begin
              // emit current digit
              out_valid_r <= 1'b1;
              addr_r <= i_r + {14'd0, wcnt_r};
              data_r <= (wcnt_r == 2'd2) ? acc_r : {4'd0, dig_r};
              last_r <= (wcnt_r == 2'd2);
            end
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
            dig_r  <= 4'd0;
            wcnt_r <= wcnt_r + 2'd1;
            if (last_r) state_r <= ST_IDLE;
            else state_r <= ST_BCD_T;
          end
        end
        ST_SAVE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
          end else if (out_ready) begin
            if (last_r) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              sidx_r <= sidx_r + 4'd1;
              addr_r <= i_r + {12'd0, sidx_r + 4'd1};
              data_r <= v_r[sidx_r + 4'd1];
              last_r <= (sidx_r + 4'd1 == x);
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = rk_r;
  assign out_mem_addr    = addr_r;
  assign out_mem_data    = data_r;
  assign out_next_pc     = pc_r;
  assign out_sound_on    = (st_r != 8'd0);
  assign out_last        = last_r;
endmodule

// ----- sv/c8x_ram.sv -----
// ----------------------------------------------------------------------------
// c8x_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module c8x_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/c8x_checker.sv -----
// ----------------------------------------------------------------------------
// c8x_checker - port-level checks for the CHIP-8 execute unit
// Watches the handshakes of the execute unit.
// ----------------------------------------------------------------------------
module c8x_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic        out_last
);
  import c8x_pkg::*;

  // one item at a time: no input transfer while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // an opcode transfer is followed by no immediate result
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_kind) |=> !out_valid) else $error("result too early");

  // only write results may be non-final
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_result_kind == RK_WRITE)
    else $error("non-final result not a write");

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_last))
    else $error("stalled result dropped");
endmodule

bind chip8_instruction_execute c8x_checker u_c8x_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready),
  .out_result_kind(out_result_kind), .out_last(out_last)
);
